// ===== sv/swmf_pkg.sv =====
// ----------------------------------------------------------------------------
// swmf_pkg
// Shared types and constants of the sliding window max filter.
// ----------------------------------------------------------------------------
package swmf_pkg;

  localparam int CFG_BITS = 7;
  localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRONT_RD,
    ST_FRONT_CHK,
    ST_BACK_RD,
    ST_BACK_CHK,
    ST_APPEND
  } swmf_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch accepted request
    logic rd_front;    // read queue front entry
    logic drop_front;  // retire front entry
    logic save_front;  // keep front value for the result
    logic rd_back;     // read queue back entry
    logic drop_back;   // retire back entry
    logic append;      // push sample, update counters, post result
  } swmf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fill_zero;
    logic fill_full;
    logic stale;       // front entry has left the window
    logic smaller;     // back entry below new sample
    logic emit;        // this sample produces a result
    logic out_block;   // result register still held
  } swmf_sts_t;

endpackage

// ===== sv/swmf_ram.sv =====
// ----------------------------------------------------------------------------
// swmf_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module swmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/swmf_ctrl.sv =====
// ----------------------------------------------------------------------------
// swmf_ctrl
// Sequencer: front expiry, back pops, append, one queue access per step.
// ----------------------------------------------------------------------------
module swmf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  swmf_pkg::swmf_sts_t sts,
  output swmf_pkg::swmf_cmd_t cmd
);
  import swmf_pkg::*;

  swmf_state_t state_r;
  swmf_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_FRONT_RD;
        end
      end
      ST_FRONT_RD: begin
        if (sts.fill_zero) begin
          state_nxt = ST_APPEND;
        end else begin
          cmd.rd_front = 1'b1;
          state_nxt    = ST_FRONT_CHK;
        end
      end
      ST_FRONT_CHK: begin
        if (sts.stale) begin
          cmd.drop_front = 1'b1;
          state_nxt      = ST_FRONT_RD;
        end else begin
          cmd.save_front = 1'b1;
          state_nxt      = ST_BACK_RD;
        end
      end
      ST_BACK_RD: begin
        if (sts.fill_zero) begin
          state_nxt = ST_APPEND;
        end else begin
          cmd.rd_back = 1'b1;
          state_nxt   = ST_BACK_CHK;
        end
      end
      ST_BACK_CHK: begin
        if (sts.smaller) begin
          cmd.drop_back = 1'b1;
          state_nxt     = ST_BACK_RD;
        end else begin
          state_nxt = ST_APPEND;
        end
      end
      ST_APPEND: begin
        // hold while this sample has a result and the previous result has not been taken
        if (!(sts.emit && sts.out_block)) begin
          cmd.append = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/swmf_dp.sv =====
// ----------------------------------------------------------------------------
// swmf_dp
// Datapath: circular candidate queue in RAM, counters, result register.
// ----------------------------------------------------------------------------
module swmf_dp #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample,
  input  logic                                   in_sequence_start,
  input  logic                                   cfg_we,
  input  logic [swmf_pkg::CFG_BITS-1:0]          cfg_wdata,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic signed [SAMPLE_BITS-1:0]          out_window_max,
  input  swmf_pkg::swmf_cmd_t                    cmd,
  output swmf_pkg::swmf_sts_t                    sts
);
  import swmf_pkg::*;

  localparam int IW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FW  = $clog2(MAX_WINDOW + 1);
  localparam int SW  = FW + 1;
  localparam int POS_MOD = 2 * MAX_WINDOW;
  localparam int PW  = $clog2(POS_MOD);
  localparam int WW  = SAMPLE_BITS + PW;

  localparam logic [SW-1:0] DEPTH_SW   = SW'(MAX_WINDOW);
  localparam logic [IW-1:0] LAST_IDX   = IW'(MAX_WINDOW - 1);
  localparam logic [PW-1:0] LAST_POS   = PW'(POS_MOD - 1);
  localparam logic [PW:0]   MOD_PW1    = (PW + 1)'(POS_MOD);
  localparam logic [31:0]   MAX_WIN32  = 32'(MAX_WINDOW);

  logic [CFG_BITS-1:0]          cfg_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic [IW-1:0]                head_r, head_nxt;
  logic [FW-1:0]                fill_r;
  logic [PW-1:0]                pos_r, pos_nxt;
  logic [FW-1:0]                warm_r, warm_nxt;
  logic signed [SAMPLE_BITS-1:0] front_r;
  logic                         out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_max_r;

  logic [FW-1:0]                win;
  logic [31:0]                  cfg32;
  logic [SW-1:0]                tail_sum, back_sum;
  logic [IW-1:0]                tail_idx, back_idx, rd_addr;
  logic [WW-1:0]                rd_word;
  logic signed [SAMPLE_BITS-1:0] rd_val;
  logic [PW-1:0]                rd_pos;
  logic [PW:0]                  age;

  // window clamp: 0 acts as 1, above depth acts as depth
  assign cfg32 = 32'(cfg_r);
  always_comb begin
    if (cfg32 == 32'd0) begin
      win = FW'(1);
    end else if (cfg32 > MAX_WIN32) begin
      win = FW'(MAX_WINDOW);
    end else begin
      win = FW'(cfg32);
    end
  end

  // circular addressing
  assign tail_sum = SW'(head_r) + SW'(fill_r);
  assign back_sum = tail_sum - SW'(1);
  assign tail_idx = (tail_sum >= DEPTH_SW) ? IW'(tail_sum - DEPTH_SW) : IW'(tail_sum);
  assign back_idx = (back_sum >= DEPTH_SW) ? IW'(back_sum - DEPTH_SW) : IW'(back_sum);
  assign rd_addr  = cmd.rd_front ? head_r : back_idx;
  assign head_nxt = (head_r == LAST_IDX) ? '0 : head_r + IW'(1);
  assign pos_nxt  = (pos_r == LAST_POS) ? '0 : pos_r + PW'(1);
  assign warm_nxt = (warm_r < win) ? warm_r + FW'(1) : win;

  swmf_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_WINDOW)
  ) u_queue (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (tail_idx),
    .wdata ({sample_r, pos_r}),
    .re    (cmd.rd_front | cmd.rd_back),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  assign rd_val = rd_word[WW-1:PW];
  assign rd_pos = rd_word[PW-1:0];
  assign age    = (pos_r >= rd_pos) ? {1'b0, pos_r} - {1'b0, rd_pos}
                                    : {1'b0, pos_r} + MOD_PW1 - {1'b0, rd_pos};

  assign sts.fill_zero = (fill_r == '0);
  assign sts.fill_full = (fill_r == FW'(MAX_WINDOW));
  assign sts.stale     = (age >= (PW + 1)'(win));
  assign sts.smaller   = (rd_val < sample_r);
  assign sts.emit      = (warm_nxt == win);
  assign sts.out_block = out_valid_r & ~out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= WINDOW_RESET;
      head_r      <= '0;
      fill_r      <= '0;
      pos_r       <= '0;
      warm_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (cmd.load && in_sequence_start) begin
        fill_r <= '0;
        warm_r <= '0;
      end
      if (cmd.drop_front) begin
        head_r <= head_nxt;
        fill_r <= fill_r - FW'(1);
      end
      if (cmd.drop_back) begin
        fill_r <= fill_r - FW'(1);
      end
      if (cmd.append) begin
        fill_r <= fill_r + FW'(1);
        pos_r  <= pos_nxt;
        warm_r <= warm_nxt;
      end
      if (cmd.append && sts.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
    end
    if (cmd.save_front) begin
      front_r <= rd_val;
    end
    if (cmd.append && sts.emit) begin
      // queue emptied by pops: the new sample is the front
      out_max_r <= sts.fill_zero ? sample_r : front_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_max = out_max_r;

endmodule

// ===== sv/sliding_window_max_filter_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_max_filter_core
// Running maximum over the last window_size signed samples (monotone queue).
// ----------------------------------------------------------------------------
//  channel  ports                                  dir  handshake
//  in       in_sample, in_sequence_start           in   in_valid / in_ready
//  out      out_window_max                         out  out_valid / out_ready
//  cfg      cfg_wdata (window_size)                in   cfg_we, no wait
//
//  A request runs load, a front read and check per stale front entry
//  dropped, and if entries remain a front read and check, back reads and
//  checks per back entry popped and for any entry kept, then append.
//  Each step is one access to the queue RAM with its registered read.
//  Synchronous active-low reset clears the counters; the queue RAM needs no
//  clearing, only entries below the fill count are read.
//  The next request is taken while a result waits; the sequencer holds at
//  append only if a new result meets an untaken one.
// ----------------------------------------------------------------------------
module sliding_window_max_filter_core #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_sequence_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_window_max,
  input  logic                          cfg_we,
  input  logic [swmf_pkg::CFG_BITS-1:0] cfg_wdata
);
  import swmf_pkg::*;

  swmf_cmd_t cmd;
  swmf_sts_t sts;

  swmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swmf_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_sample         (in_sample),
    .in_sequence_start (in_sequence_start),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_window_max    (out_window_max),
    .cmd               (cmd),
    .sts               (sts)
  );

  // queue never overflows: every entry kept is younger than the window
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> !sts.fill_full)
    else $error("append into full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.drop_back || cmd.drop_front) |-> !sts.fill_zero)
    else $error("queue entry retired from empty queue");

  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_ready)
    else $error("request taken while previous one in progress");

  a_result_from_append: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.append && sts.emit))
    else $error("result posted outside append");

endmodule
